// ===== hw/rtl/css_pkg.sv =====
// Shared types and constants for the cosine similarity stream unit.
package css_pkg;

    localparam int COS_W    = 16;
    localparam int COS_FRAC = 14;
    localparam logic [COS_W-1:0] COS_ONE = 16'd16384;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_OVER = 2'd2
    } status_code_t;

    typedef enum logic [3:0] {
        S_ACC,
        S_DRAIN,
        S_SQA_LD,
        S_SQA,
        S_SQB_LD,
        S_SQB,
        S_MUL,
        S_DV_LD,
        S_DV,
        S_FIN
    } state_t;

    typedef struct packed {
        logic take_pair;
        logic sq_load_a;
        logic sq_load_b;
        logic sq_step;
        logic mul_go;
        logic dv_load;
        logic dv_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic sq_last;
        logic dv_last;
    } sts_t;

endpackage

// ===== hw/rtl/cosine_similarity_stream_unit.sv =====
// Top level of the streaming cosine similarity unit.
//
// Input channel: one beat carries a_elem and b_elem (signed Q8.8) and
// last_pair; a beat moves when in_valid is high and in_stall is low.
// Pairs are taken one per cycle while a vector pair is accumulating.
// Output channel: one beat (cosine in signed Q1.14, status) per beat
// marked last_pair; it moves when out_valid is high and out_stall is low.
// After the last beat of a vector pair the sequencer runs two square roots
// of RT_W steps each, one length multiply and a bit-serial divide of NW
// steps, with SUM_W = 2*ELEM_WIDTH + clog2(MAX_LEN) + 1, RT_W =
// ceil(SUM_W/2) and NW = SUM_W + 14. in_stall is high for that whole
// sequence. A held result does not stop the next vector pair from
// accumulating; only its final load waits on out_stall.
// Reset clears all sums, the pair count and the overflow flag, and drops
// any result still waiting on the output.
module cosine_similarity_stream_unit
    import css_pkg::*;
#(
    parameter int MAX_LEN    = 1024,
    parameter int ELEM_WIDTH = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [ELEM_WIDTH-1:0] a_elem,
    input  logic signed [ELEM_WIDTH-1:0] b_elem,
    input  logic                         last_pair,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COS_W-1:0]      cosine,
    output logic [1:0]                   status
);

    cmd_t cmd;
    sts_t sts;

    css_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_pair (last_pair),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    css_datapath #(
        .MAX_LEN    (MAX_LEN),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .a_elem (a_elem),
        .b_elem (b_elem),
        .cmd    (cmd),
        .sts    (sts),
        .cosine (cosine),
        .status (status)
    );

endmodule

// ===== hw/rtl/css_ctrl.sv =====
// Sequencer for accumulation, square roots, length product and division.
module css_ctrl
    import css_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic last_pair,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_ACC:
            begin
                if (in_valid && last_pair)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:  state_next = S_SQA_LD;
            S_SQA_LD: state_next = S_SQA;
            S_SQA:
            begin
                if (sts.sq_last)
                begin
                    state_next = S_SQB_LD;
                end
            end
            S_SQB_LD: state_next = S_SQB;
            S_SQB:
            begin
                if (sts.sq_last)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:    state_next = S_DV_LD;
            S_DV_LD:  state_next = S_DV;
            S_DV:
            begin
                if (sts.dv_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_ACC;
                end
            end
            default:  state_next = S_ACC;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        unique case (state_reg)
            S_ACC:
            begin
                in_stall      = 1'b0;
                cmd.take_pair = in_valid;
            end
            S_SQA_LD: cmd.sq_load_a = 1'b1;
            S_SQA:    cmd.sq_step   = 1'b1;
            S_SQB_LD: cmd.sq_load_b = 1'b1;
            S_SQB:    cmd.sq_step   = 1'b1;
            S_MUL:    cmd.mul_go    = 1'b1;
            S_DV_LD:  cmd.dv_load   = 1'b1;
            S_DV:     cmd.dv_step   = 1'b1;
            S_FIN:    cmd.finish    = out_free;
            default:  cmd           = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hw/rtl/css_datapath.sv =====
// Sums, shared square root unit, length multiplier and serial divider.
module css_datapath
    import css_pkg::*;
#(
    parameter int MAX_LEN    = 1024,
    parameter int ELEM_WIDTH = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic signed [ELEM_WIDTH-1:0] a_elem,
    input  logic signed [ELEM_WIDTH-1:0] b_elem,
    input  cmd_t                         cmd,
    output sts_t                         sts,
    output logic signed [COS_W-1:0]      cosine,
    output logic [1:0]                   status
);

    localparam int PW    = 2 * ELEM_WIDTH;
    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int SUM_W = PW + $clog2(MAX_LEN) + 1;
    localparam int RT_W  = (SUM_W + 1) / 2;
    localparam int SQ_W  = 2 * RT_W;
    localparam int RW    = RT_W + 2;
    localparam int DW    = 2 * RT_W;
    localparam int NW    = SUM_W + COS_FRAC;
    localparam int SQ_CW = $clog2(RT_W);
    localparam int DV_CW = $clog2(NW);

    logic signed [PW-1:0]    prod_ab_reg;
    logic [PW-1:0]           prod_aa_reg;
    logic [PW-1:0]           prod_bb_reg;
    logic                    prod_valid_reg;
    logic signed [SUM_W-1:0] dot_reg;
    logic [SUM_W-1:0]        na_reg;
    logic [SUM_W-1:0]        nb_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    ovf_reg;

    logic [SQ_W-1:0]         sq_val_reg;
    logic [RW-1:0]           sq_rem_reg;
    logic [RT_W-1:0]         sq_root_reg;
    logic [SQ_CW-1:0]        sq_cnt_reg;
    logic [RT_W-1:0]         len_a_reg;
    logic [DW-1:0]           den_reg;

    logic [NW-1:0]           dv_num_reg;
    logic [DW-1:0]           dv_rem_reg;
    logic [NW-1:0]           dv_q_reg;
    logic [DV_CW-1:0]        dv_cnt_reg;
    logic                    neg_reg;

    logic signed [COS_W-1:0] cosine_reg;
    logic [1:0]              status_reg;

    logic [RW-1:0]           sq_sh;
    logic [RW-1:0]           sq_trial;
    logic [DW:0]             dv_sh;
    logic [DW:0]             dv_den;
    logic [SUM_W-1:0]        dot_mag;
    logic                    len_zero;
    logic [COS_W-1:0]        q_clamp;
    status_code_t            st_code;

    assign sq_sh    = {sq_rem_reg[RT_W-1:0], sq_val_reg[SQ_W-1 -: 2]};
    assign sq_trial = {sq_root_reg, 2'b01};
    assign dv_den   = {1'b0, den_reg};
    assign dv_sh    = {dv_rem_reg, dv_num_reg[NW-1]};
    assign dot_mag  = dot_reg[SUM_W-1] ? SUM_W'(-dot_reg) : SUM_W'(dot_reg);
    assign len_zero = (len_a_reg == '0) || (sq_root_reg == '0);
    assign q_clamp  = (dv_q_reg > NW'(COS_ONE)) ? COS_ONE : dv_q_reg[COS_W-1:0];

    assign sts.sq_last = (sq_cnt_reg == SQ_CW'(RT_W - 1));
    assign sts.dv_last = (dv_cnt_reg == DV_CW'(NW - 1));

    always_comb
    begin
        if (ovf_reg)
        begin
            st_code = ST_OVER;
        end
        else if (len_zero)
        begin
            st_code = ST_ZERO;
        end
        else
        begin
            st_code = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            dot_reg        <= '0;
            na_reg         <= '0;
            nb_reg         <= '0;
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
        end
        else if (cmd.finish)
        begin
            prod_valid_reg <= 1'b0;
            dot_reg        <= '0;
            na_reg         <= '0;
            nb_reg         <= '0;
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= 1'b0;
            if (cmd.take_pair)
            begin
                if (cnt_reg != CNT_W'(MAX_LEN))
                begin
                    prod_valid_reg <= 1'b1;
                    cnt_reg        <= cnt_reg + 1'b1;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (prod_valid_reg)
            begin
                dot_reg <= dot_reg + SUM_W'(prod_ab_reg);
                na_reg  <= na_reg + SUM_W'(prod_aa_reg);
                nb_reg  <= nb_reg + SUM_W'(prod_bb_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_pair)
        begin
            prod_ab_reg <= PW'(a_elem) * PW'(b_elem);
            prod_aa_reg <= PW'(a_elem) * PW'(a_elem);
            prod_bb_reg <= PW'(b_elem) * PW'(b_elem);
        end

        if (cmd.sq_load_a || cmd.sq_load_b)
        begin
            sq_val_reg  <= cmd.sq_load_b ? SQ_W'(nb_reg) : SQ_W'(na_reg);
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
            sq_cnt_reg  <= '0;
        end
        else if (cmd.sq_step)
        begin
            sq_val_reg <= sq_val_reg << 2;
            sq_cnt_reg <= sq_cnt_reg + 1'b1;
            if (sq_sh >= sq_trial)
            begin
                sq_rem_reg  <= sq_sh - sq_trial;
                sq_root_reg <= {sq_root_reg[RT_W-2:0], 1'b1};
            end
            else
            begin
                sq_rem_reg  <= sq_sh;
                sq_root_reg <= {sq_root_reg[RT_W-2:0], 1'b0};
            end
        end

        if (cmd.sq_load_b)
        begin
            len_a_reg <= sq_root_reg;
        end

        if (cmd.mul_go)
        begin
            den_reg <= DW'(len_a_reg) * DW'(sq_root_reg);
        end

        if (cmd.dv_load)
        begin
            dv_num_reg <= NW'(dot_mag) << COS_FRAC;
            dv_rem_reg <= '0;
            dv_q_reg   <= '0;
            dv_cnt_reg <= '0;
            neg_reg    <= dot_reg[SUM_W-1];
        end
        else if (cmd.dv_step)
        begin
            dv_num_reg <= dv_num_reg << 1;
            dv_cnt_reg <= dv_cnt_reg + 1'b1;
            if (dv_sh >= dv_den)
            begin
                dv_rem_reg <= DW'(dv_sh - dv_den);
                dv_q_reg   <= {dv_q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                dv_rem_reg <= dv_sh[DW-1:0];
                dv_q_reg   <= {dv_q_reg[NW-2:0], 1'b0};
            end
        end

        if (cmd.finish)
        begin
            status_reg <= st_code;
            if (len_zero)
            begin
                cosine_reg <= '0;
            end
            else if (neg_reg)
            begin
                cosine_reg <= -signed'(q_clamp);
            end
            else
            begin
                cosine_reg <= signed'(q_clamp);
            end
        end
    end

    assign cosine = cosine_reg;
    assign status = status_reg;

endmodule
